/* rtl/ovn_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ovn_pkg;

  // Table geometry
  localparam int unsigned SAMPLES  = 128;
  localparam int unsigned IDX_W    = $clog2(SAMPLES);
  localparam int unsigned OCT_MAX  = IDX_W + 1;
  localparam int unsigned OCT_W    = 4;
  localparam int unsigned SH_W     = $clog2(IDX_W + 1);
  localparam int unsigned PITCH_W  = IDX_W + 1;

  // Fixed-point formats
  localparam int unsigned SEED_W    = 16;
  localparam int unsigned BIAS_W    = 16;
  localparam int unsigned BIAS_FRAC = 8;
  localparam int unsigned BIAS_MIN  = 1 << BIAS_FRAC;
  localparam int unsigned W_W       = SEED_W + 1;
  localparam int unsigned W_ONE     = 1 << SEED_W;
  localparam int unsigned WSUM_W    = W_W + $clog2(OCT_MAX);
  localparam int unsigned ACC_W     = SEED_W + W_W + $clog2(OCT_MAX);
  localparam int unsigned BLEND_W   = SEED_W + IDX_W;

  // Shared multiplier and divider
  localparam int unsigned MUL_W     = W_W;
  localparam int unsigned PROD_W    = 2 * MUL_W;
  localparam int unsigned DIV_Q_W   = W_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_Q_W + 1);

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OCTAVE_COUNT = 1'b0,
    CFG_SCALE_BIAS   = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    MODE_LOAD  = 1'b0,
    MODE_QUERY = 1'b1
  } mode_e;

  typedef struct packed {
    logic [OCT_W-1:0]  octave_count;
    logic [BIAS_W-1:0] scale_bias;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    mode_e             mode;
    logic [IDX_W-1:0]  position;
    logic [SEED_W-1:0] seed_value;
  } req_t;

  typedef struct packed {
    logic              busy;
    logic              res_valid;
    logic [SEED_W-1:0] res_value;
  } stat_t;

  typedef struct packed {
    logic                 start;
    logic [WSUM_W-1:0]    hi;
    logic [DIV_Q_W-1:0]   lo;
    logic [WSUM_W-1:0]    den;
    logic [DIV_CNT_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_Q_W-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

/* rtl/ovn_div.sv */
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle. The caller splits the
// dividend into a high part below the divisor and a low part left-aligned
// in the shift register; after the given number of steps the quotient sits
// in the low bits of the shift register.
module ovn_div import ovn_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  logic [WSUM_W-1:0]    rem_q, rem_d;
  logic [WSUM_W-1:0]    den_q, den_d;
  logic [DIV_Q_W-1:0]   sh_q, sh_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 done_q, done_d;
  logic [WSUM_W:0]      trial;
  logic                 ge;

  // Trial subtract of one shifted-in dividend bit
  always_comb begin
    trial = {rem_q, sh_q[DIV_Q_W-1]};
    ge    = trial >= {1'b0, den_q};
  end

  // Load on start, then advance one bit per cycle
  always_comb begin
    rem_d  = rem_q;
    den_d  = den_q;
    sh_d   = sh_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d = req_i.hi;
      den_d = req_i.den;
      sh_d  = req_i.lo;
      cnt_d = req_i.steps;
    end else if (cnt_q != '0) begin
      rem_d  = ge ? WSUM_W'(trial - {1'b0, den_q}) : trial[WSUM_W-1:0];
      sh_d   = {sh_q[DIV_Q_W-2:0], ge};
      cnt_d  = cnt_q - DIV_CNT_W'(1);
      done_d = (cnt_q == DIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    sh_q  <= sh_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = sh_q;

endmodule

`default_nettype wire

/* rtl/ovn_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Seed store plus the octave sequencer. One multiplier serves the two blend
// products and the weighting product; one divider serves the weight update
// and the final normalization.
module ovn_core import ovn_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cfg_t cfg_i,
  input  wire req_t req_i,
  input  wire logic res_take_i,
  output stat_t     stat_o
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_RDA    = 11'b000_0000_0010,
    S_RDB    = 11'b000_0000_0100,
    S_MULB   = 11'b000_0000_1000,
    S_INTERP = 11'b000_0001_0000,
    S_MULW   = 11'b000_0010_0000,
    S_ACC    = 11'b000_0100_0000,
    S_WDIV   = 11'b000_1000_0000,
    S_FDIV   = 11'b001_0000_0000,
    S_FWAIT  = 11'b010_0000_0000,
    S_DONE   = 11'b100_0000_0000
  } state_e;

  state_e              state_q, state_d;
  logic [IDX_W-1:0]    pos_q, pos_d;
  logic [OCT_W-1:0]    oct_q, oct_d;
  logic [W_W-1:0]      w_q, w_d;
  logic [ACC_W-1:0]    acc_q, acc_d;
  logic [WSUM_W-1:0]   wsum_q, wsum_d;
  logic [PROD_W-1:0]   prod_q, prod_d;
  logic [BLEND_W-1:0]  blend_q, blend_d;
  logic [SEED_W-1:0]   interp_q, interp_d;
  logic [SEED_W-1:0]   res_q, res_d;

  logic [SEED_W-1:0]   seed_mem [SAMPLES];
  logic [SEED_W-1:0]   rdata_q;
  logic [IDX_W-1:0]    rd_addr;
  logic                seed_we;

  logic [OCT_W-1:0]    oct_lim;
  logic [BIAS_W-1:0]   bias_eff;
  logic                last_oct;
  logic [SH_W-1:0]     sh;
  logic [PITCH_W-1:0]  pitch;
  logic [IDX_W-1:0]    mask;
  logic [IDX_W-1:0]    s1, s2, ofs;
  logic [PITCH_W-1:0]  pitch_left;
  logic [BLEND_W:0]    blend_sum;
  logic [BLEND_W:0]    blend_shr;
  logic [ACC_W-1:0]    fin_num;
  logic [MUL_W-1:0]    mul_a, mul_b;
  logic [PROD_W-1:0]   mul_p;

  div_req_t            div_req;
  div_rsp_t            div_rsp;

  // Clamp the configuration to the usable range
  always_comb begin
    if (cfg_i.octave_count == '0) begin
      oct_lim = OCT_W'(1);
    end else if (cfg_i.octave_count > OCT_W'(OCT_MAX)) begin
      oct_lim = OCT_W'(OCT_MAX);
    end else begin
      oct_lim = cfg_i.octave_count;
    end
    bias_eff = (cfg_i.scale_bias < BIAS_W'(BIAS_MIN)) ? BIAS_W'(BIAS_MIN) : cfg_i.scale_bias;
    last_oct = (oct_q == oct_lim - OCT_W'(1));
  end

  // Sample pair for the current octave; the pitch is a power of two
  always_comb begin
    sh         = SH_W'(IDX_W) - SH_W'(oct_q);
    pitch      = PITCH_W'(1) << sh;
    mask       = IDX_W'(pitch - PITCH_W'(1));
    s1         = pos_q & ~mask;
    ofs        = pos_q & mask;
    s2         = s1 + pitch[IDX_W-1:0];
    pitch_left = pitch - PITCH_W'(ofs);
    rd_addr    = (state_q == S_RDB) ? s2 : s1;
  end

  // Seed store, registered read
  assign seed_we = req_i.valid && (req_i.mode == MODE_LOAD);

  always_ff @(posedge clk_i) begin
    if (seed_we) begin
      seed_mem[req_i.position] <= req_i.seed_value;
    end
    rdata_q <= seed_mem[rd_addr];
  end

  // Shared multiplier operand select
  always_comb begin
    case (state_q)
      S_RDB: begin
        mul_a = MUL_W'(rdata_q);
        mul_b = MUL_W'(pitch_left);
      end
      S_MULB: begin
        mul_a = MUL_W'(rdata_q);
        mul_b = MUL_W'(ofs);
      end
      default: begin
        mul_a = MUL_W'(interp_q);
        mul_b = w_q;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // Blend and normalizing sum
  always_comb begin
    blend_sum = (BLEND_W + 1)'(blend_q) + (BLEND_W + 1)'(prod_q[BLEND_W-1:0]);
    blend_shr = blend_sum >> sh;
    fin_num   = acc_q + ACC_W'(wsum_q >> 1);
  end

  // Sequencer
  always_comb begin
    state_d  = state_q;
    pos_d    = pos_q;
    oct_d    = oct_q;
    w_d      = w_q;
    acc_d    = acc_q;
    wsum_d   = wsum_q;
    prod_d   = prod_q;
    blend_d  = blend_q;
    interp_d = interp_q;
    res_d    = res_q;
    div_req  = '0;
    case (state_q)
      S_IDLE: begin
        if (req_i.valid && (req_i.mode == MODE_QUERY)) begin
          pos_d   = req_i.position;
          oct_d   = '0;
          w_d     = W_W'(W_ONE);
          acc_d   = '0;
          wsum_d  = '0;
          state_d = S_RDA;
        end
      end
      S_RDA: begin
        state_d = S_RDB;
      end
      S_RDB: begin
        prod_d  = mul_p;
        state_d = S_MULB;
      end
      S_MULB: begin
        blend_d = prod_q[BLEND_W-1:0];
        prod_d  = mul_p;
        state_d = S_INTERP;
      end
      S_INTERP: begin
        interp_d = blend_shr[SEED_W-1:0];
        state_d  = S_MULW;
      end
      S_MULW: begin
        prod_d  = mul_p;
        state_d = S_ACC;
      end
      S_ACC: begin
        acc_d  = acc_q + ACC_W'(prod_q);
        wsum_d = wsum_q + WSUM_W'(w_q);
        if (last_oct) begin
          state_d = S_FDIV;
        end else begin
          // next weight = w * 256 / bias
          div_req.start = 1'b1;
          div_req.hi    = WSUM_W'(w_q >> (W_W - BIAS_FRAC));
          div_req.lo    = {w_q[W_W-BIAS_FRAC-1:0], {BIAS_FRAC{1'b0}}};
          div_req.den   = WSUM_W'(bias_eff);
          div_req.steps = DIV_CNT_W'(DIV_Q_W);
          state_d       = S_WDIV;
        end
      end
      S_WDIV: begin
        if (div_rsp.done) begin
          w_d     = div_rsp.quot;
          oct_d   = oct_q + OCT_W'(1);
          state_d = S_RDA;
        end
      end
      S_FDIV: begin
        // rounded weighted mean = (acc + wsum/2) / wsum
        div_req.start = 1'b1;
        div_req.hi    = fin_num[ACC_W-1:SEED_W];
        div_req.lo    = {fin_num[SEED_W-1:0], 1'b0};
        div_req.den   = wsum_q;
        div_req.steps = DIV_CNT_W'(SEED_W);
        state_d       = S_FWAIT;
      end
      S_FWAIT: begin
        if (div_rsp.done) begin
          res_d   = div_rsp.quot[SEED_W-1:0];
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  ovn_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    oct_q    <= oct_d;
    w_q      <= w_d;
    acc_q    <= acc_d;
    wsum_q   <= wsum_d;
    prod_q   <= prod_d;
    blend_q  <= blend_d;
    interp_q <= interp_d;
    res_q    <= res_d;
  end

  assign stat_o.busy      = (state_q != S_IDLE);
  assign stat_o.res_valid = (state_q == S_DONE);
  assign stat_o.res_value = res_q;

endmodule

`default_nettype wire

/* rtl/octave_value_noise_1d.sv */
`timescale 1ns / 1ps
`default_nettype none

// One-dimensional octave value noise over a 128-entry seed store. A load
// transfer (mode 0) writes one seed and does not make the block busy. A
// query transfer (mode 1) walks the octaves with one shared multiplier and
// one shared bit-serial divider: each octave reads its sample pair, blends
// and weights it and accumulates, then runs the weight division, or on the
// last octave the final rounded normalization, with at most eight effective
// octaves; once the result moves into the output register, the next item
// can be taken. The divider yields one quotient bit per cycle.
// in_stall_o stays high while a query is in flight. The result sits in an
// output register, so the next item is taken while it waits. Seeds must be
// loaded before a query reads them.
module octave_value_noise_1d import ovn_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic                  mode_i,
  input  wire logic [IDX_W-1:0]      position_i,
  input  wire logic [SEED_W-1:0]     seed_value_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [SEED_W-1:0]          noise_value_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  logic [OCT_W-1:0]  octave_count_q, octave_count_d;
  logic [BIAS_W-1:0] scale_bias_q, scale_bias_d;
  logic              out_valid_q, out_valid_d;
  logic [SEED_W-1:0] out_data_q, out_data_d;
  logic              in_xfer;
  logic              res_take;
  cfg_t              cfg;
  req_t              req;
  stat_t             stat;

  // Configuration writes
  always_comb begin
    octave_count_d = octave_count_q;
    scale_bias_d   = scale_bias_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_OCTAVE_COUNT: octave_count_d = cfg_wdata_i[OCT_W-1:0];
        CFG_SCALE_BIAS:   scale_bias_d   = cfg_wdata_i[BIAS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      octave_count_q <= OCT_W'(7);
      scale_bias_q   <= BIAS_W'(819);
    end else begin
      octave_count_q <= octave_count_d;
      scale_bias_q   <= scale_bias_d;
    end
  end

  assign cfg.octave_count = octave_count_q;
  assign cfg.scale_bias   = scale_bias_q;

  // Input transfer
  assign in_stall_o     = stat.busy;
  assign in_xfer        = in_valid_i && !in_stall_o;
  assign req.valid      = in_xfer;
  assign req.mode       = mode_e'(mode_i);
  assign req.position   = position_i;
  assign req.seed_value = seed_value_i;

  ovn_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .req_i      (req),
    .res_take_i (res_take),
    .stat_o     (stat)
  );

  // Output register: load a finished result when empty or draining
  assign res_take = stat.res_valid && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (res_take) begin
      out_valid_d = 1'b1;
      out_data_d  = stat.res_value;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o   = out_valid_q;
  assign noise_value_o = out_data_q;

  // A query occupies the sequencer on the following cycle
  a_query_holds_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && (mode_i == MODE_QUERY)) |=> in_stall_o)
    else $error("query accepted but block not busy");

  // A load completes in the cycle it is accepted
  a_load_single_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && (mode_i == MODE_LOAD)) |=> !in_stall_o)
    else $error("load left the block busy");

  // Output valid only rises from a finished query
  a_result_from_core: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(stat.res_valid))
    else $error("output valid without a finished query");

endmodule

`default_nettype wire
